### design/mht_pkg.sv
// Shared types, codes and the byte classifier for the mail header tokenizer.
`timescale 1ns / 1ps

package mht_pkg;

    localparam int LEN_BITS   = 16;
    localparam int NEST_BITS  = 8;
    localparam int QDEPTH     = 4;
    localparam int QPTR_BITS  = $clog2(QDEPTH);

    localparam logic [LEN_BITS-1:0]  LEN_MAX  = {LEN_BITS{1'b1}};
    localparam logic [NEST_BITS-1:0] NEST_MAX = 8'd255;

    // token classes
    localparam logic [3:0] C_ATOM    = 4'd0;
    localparam logic [3:0] C_SPACE   = 4'd1;
    localparam logic [3:0] C_COMMENT = 4'd2;
    localparam logic [3:0] C_QUOTED  = 4'd3;
    localparam logic [3:0] C_ESCAPED = 4'd4;
    localparam logic [3:0] C_DOMLIT  = 4'd5;
    localparam logic [3:0] C_SPECIAL = 4'd6;
    localparam logic [3:0] C_CONTROL = 4'd7;
    localparam logic [3:0] C_HIGH    = 4'd8;

    // delimiter bytes
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    typedef enum logic [2:0] {
        K_NONE    = 3'd0,
        K_ATOM    = 3'd1,
        K_SPACE   = 3'd2,
        K_COMMENT = 3'd3,
        K_QUOTED  = 3'd4,
        K_DOMLIT  = 3'd5,
        K_ESCAPE  = 3'd6
    } kind_t;

    typedef struct packed {
        logic [3:0]          token_class;
        logic [LEN_BITS-1:0] token_length;
        logic                unterminated;
        logic                final_token;
    } result_t;

    // one queue entry: the results caused by one byte
    typedef struct packed {
        logic    two;
        result_t r1;
        result_t r0;
    } entry_t;

    function automatic logic [3:0] class_of(input logic [7:0] b);
        logic [6:0] c;
        logic [3:0] r;
        c = b[6:0];
        if (c == 7'd0) begin
            r = C_HIGH;
        end else if (c == 7'h20 || c == 7'h09 || c == 7'h0A || c == 7'h0D) begin
            r = C_SPACE;
        end else if (c < 7'h20) begin
            r = C_CONTROL;
        end else begin
            case (c)
                7'h22:   r = C_QUOTED;
                7'h28:   r = C_COMMENT;
                7'h5B:   r = C_DOMLIT;
                7'h5C:   r = C_ESCAPED;
                7'h29, 7'h3C, 7'h3E, 7'h40, 7'h2C, 7'h3B, 7'h3A, 7'h2E, 7'h5D:
                         r = C_SPECIAL;
                default: r = C_ATOM;
            endcase
        end
        return r;
    endfunction

endpackage

### design/mht_front.sv
// Front end: takes bytes, classifies them and runs the token state, emitting queue entries.
`timescale 1ns / 1ps

module mht_front
    import mht_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_fire,
    input  logic [7:0]  byte_in,
    input  logic        last_byte,
    output logic        push,
    output entry_t      push_entry
);

    kind_t                kind_reg, kind_next;
    logic [LEN_BITS-1:0]  len_reg, len_next;
    logic [NEST_BITS-1:0] depth_reg, depth_next;
    logic                 esc_reg, esc_next;

    logic [3:0]          cls;
    logic [3:0]          run_cls;
    logic [3:0]          tcls;
    logic [LEN_BITS-1:0] len_inc;
    logic                closed;
    logic                start;
    logic                new_emit;
    result_t             new_res;
    result_t             r0, r1;
    logic [1:0]          n;

    assign cls     = class_of(byte_in);
    assign len_inc = (len_reg == LEN_MAX) ? len_reg : len_reg + 1'b1;
    assign run_cls = (kind_reg == K_ATOM) ? C_ATOM : C_SPACE;
    assign tcls    = (kind_reg == K_COMMENT) ? C_COMMENT :
                     (kind_reg == K_QUOTED)  ? C_QUOTED : C_DOMLIT;

    always_comb begin
        kind_next  = kind_reg;
        len_next   = len_reg;
        depth_next = depth_reg;
        esc_next   = esc_reg;
        r0         = '0;
        r1         = '0;
        n          = 2'd0;
        start      = 1'b0;
        closed     = 1'b0;
        new_emit   = 1'b0;
        new_res    = '0;

        case (kind_reg)
            K_ATOM, K_SPACE: begin
                if (cls == run_cls) begin
                    len_next = len_inc;
                    if (last_byte) begin
                        r0 = '{run_cls, len_inc, 1'b0, 1'b1};
                        n = 2'd1;
                        kind_next = K_NONE;
                        len_next = '0;
                    end
                end else begin
                    r0 = '{run_cls, len_reg, 1'b0, 1'b0};
                    n = 2'd1;
                    kind_next = K_NONE;
                    len_next = '0;
                    start = 1'b1;
                end
            end
            K_ESCAPE: begin
                r0 = '{C_ESCAPED, LEN_BITS'(2), 1'b0, last_byte};
                n = 2'd1;
                kind_next = K_NONE;
                len_next = '0;
            end
            K_COMMENT, K_QUOTED, K_DOMLIT: begin
                len_next = len_inc;
                if (esc_reg) begin
                    esc_next = 1'b0;
                end else if (byte_in == CH_BSLASH) begin
                    esc_next = 1'b1;
                end else if (kind_reg == K_COMMENT) begin
                    if (byte_in == CH_LPAREN) begin
                        if (depth_reg != NEST_MAX) depth_next = depth_reg + 1'b1;
                    end else if (byte_in == CH_RPAREN) begin
                        if (depth_reg != '0) depth_next = depth_reg - 1'b1;
                        else closed = 1'b1;
                    end
                end else if (kind_reg == K_QUOTED) begin
                    closed = (byte_in == CH_DQUOTE);
                end else begin
                    closed = (byte_in == CH_RBRACK);
                end
                if (closed || last_byte) begin
                    r0 = '{tcls, len_inc, ~closed, last_byte};
                    n = 2'd1;
                    kind_next = K_NONE;
                    len_next = '0;
                    depth_next = '0;
                    esc_next = 1'b0;
                end
            end
            K_NONE: begin
                start = 1'b1;
            end
            default: begin
                kind_next = K_NONE;
                len_next = '0;
                depth_next = '0;
                esc_next = 1'b0;
            end
        endcase

        // byte opens a new token
        if (start) begin
            case (cls)
                C_ATOM, C_SPACE: begin
                    if (last_byte) begin
                        new_emit = 1'b1;
                        new_res = '{cls, LEN_BITS'(1), 1'b0, 1'b1};
                    end else begin
                        kind_next = (cls == C_ATOM) ? K_ATOM : K_SPACE;
                        len_next = LEN_BITS'(1);
                    end
                end
                C_COMMENT, C_QUOTED, C_DOMLIT: begin
                    if (last_byte) begin
                        new_emit = 1'b1;
                        new_res = '{cls, LEN_BITS'(1), 1'b1, 1'b1};
                    end else begin
                        kind_next = (cls == C_COMMENT) ? K_COMMENT :
                                    (cls == C_QUOTED)  ? K_QUOTED : K_DOMLIT;
                        len_next = LEN_BITS'(1);
                        depth_next = '0;
                        esc_next = 1'b0;
                    end
                end
                C_ESCAPED: begin
                    if (last_byte) begin
                        new_emit = 1'b1;
                        new_res = '{C_ESCAPED, LEN_BITS'(1), 1'b1, 1'b1};
                    end else begin
                        kind_next = K_ESCAPE;
                        len_next = LEN_BITS'(1);
                    end
                end
                default: begin
                    new_emit = 1'b1;
                    new_res = '{cls, LEN_BITS'(1), 1'b0, last_byte};
                end
            endcase
            if (new_emit) begin
                if (n == 2'd0) r0 = new_res;
                else           r1 = new_res;
                n = n + 2'd1;
            end
        end
    end

    assign push       = in_fire && (n != 2'd0);
    assign push_entry = '{(n == 2'd2), r1, r0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg  <= K_NONE;
            len_reg   <= '0;
            depth_reg <= '0;
            esc_reg   <= 1'b0;
        end else if (in_fire) begin
            kind_reg  <= kind_next;
            len_reg   <= len_next;
            depth_reg <= depth_next;
            esc_reg   <= esc_next;
        end
    end

endmodule

### design/mht_fifo.sv
// Short entry queue between the front end and the result stage.
`timescale 1ns / 1ps

module mht_fifo
    import mht_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t pop_entry,
    output logic   empty,
    output logic   full
);

    entry_t               mem_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == (QPTR_BITS+1)'(QDEPTH));
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

### design/mht_back.sv
// Result stage: unpacks queue entries into single result transfers.
`timescale 1ns / 1ps

module mht_back
    import mht_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  entry_t  q_entry,
    input  logic    q_empty,
    output logic    q_pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    valid_reg;
    result_t res_reg;
    logic    second_valid_reg;
    result_t second_reg;
    logic    advance;

    assign advance   = !valid_reg || out_ready;
    assign q_pop     = advance && !second_valid_reg && !q_empty;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg        <= 1'b0;
            second_valid_reg <= 1'b0;
        end else if (advance) begin
            if (second_valid_reg) begin
                valid_reg        <= 1'b1;
                second_valid_reg <= 1'b0;
            end else begin
                valid_reg        <= !q_empty;
                second_valid_reg <= !q_empty && q_entry.two;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            if (second_valid_reg) begin
                res_reg <= second_reg;
            end else if (!q_empty) begin
                res_reg    <= q_entry.r0;
                second_reg <= q_entry.r1;
            end
        end
    end

endmodule

### design/mail_header_tokenizer.sv
// Top level of the mail header tokenizer: front end, entry queue and result stage.
`timescale 1ns / 1ps
// Throughput: one byte per cycle in while the queue is not full; one result per cycle
//   out while m_tready is high (a byte that closes a run and forms a token of its own
//   yields two results in turn). Path: the front end decodes in the transfer cycle and
//   writes the entry queue, which feeds the output register that drives m_tvalid.
// Reset: aresetn low clears the token state, the queue and the output register.

module mail_header_tokenizer
    import mht_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [3:0] token_class, [19:4] token_length, [23:20] zero
    output logic        m_tuser,   // unterminated
    output logic        m_tlast    // final_token
);

    logic    in_fire;
    logic    push;
    entry_t  push_entry;
    entry_t  q_entry;
    logic    q_empty;
    logic    q_full;
    logic    q_pop;
    result_t out_res;

    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    mht_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .byte_in    (s_tdata),
        .last_byte  (s_tlast),
        .push       (push),
        .push_entry (push_entry)
    );

    mht_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .pop_entry  (q_entry),
        .empty      (q_empty),
        .full       (q_full)
    );

    mht_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_entry   (q_entry),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {4'd0, out_res.token_length, out_res.token_class};
    assign m_tuser = out_res.unterminated;
    assign m_tlast = out_res.final_token;

endmodule

### tb/tb_mail_header_tokenizer.sv
// Self-checking testbench for the mail header tokenizer: byte stream in, token reports out.
`timescale 1ns / 1ps

module tb_mail_header_tokenizer;
    import mht_pkg::*;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } hdr_byte_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    mail_header_tokenizer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    hdr_byte_t   header_bytes[$];   // bytes waiting to be sent
    logic [7:0]  str_q[$];          // string under construction
    result_t     expected_tokens[$];
    bit          holding    = 1'b0;
    int          send_idle  = 0;
    int          recv_idle  = 0;
    int          queued     = 0;
    int          mismatches = 0;

    // predictor state
    kind_t       lex_kind  = K_NONE;
    logic [15:0] lex_len   = '0;
    logic [7:0]  lex_depth = '0;
    logic        lex_esc   = 1'b0;

    function automatic logic [3:0] byte_kind(input logic [7:0] b);
        logic [6:0] c;
        c = b[6:0];
        if (c == 7'd0)
            return C_HIGH;
        if (c == 7'h20 || c == 7'h09 || c == 7'h0A || c == 7'h0D)
            return C_SPACE;
        if (c < 7'h20)
            return C_CONTROL;
        case (c)
            7'h22: return C_QUOTED;
            7'h28: return C_COMMENT;
            7'h5B: return C_DOMLIT;
            7'h5C: return C_ESCAPED;
            7'h29, 7'h3C, 7'h3E, 7'h40, 7'h2C, 7'h3B, 7'h3A, 7'h2E, 7'h5D: return C_SPECIAL;
            default: return C_ATOM;
        endcase
    endfunction

    task automatic emit_token(input logic [3:0] cls, input logic [15:0] len,
                              input logic unterm, input logic fin);
        result_t t;
        t.token_class  = cls;
        t.token_length = len;
        t.unterminated = unterm;
        t.final_token  = fin;
        expected_tokens.push_back(t);
    endtask

    task automatic clear_lexer();
        lex_kind  = K_NONE;
        lex_len   = '0;
        lex_depth = '0;
        lex_esc   = 1'b0;
    endtask

    task automatic lex_byte(input logic [7:0] b, input logic last);
        logic [3:0] cls;
        logic [3:0] run;
        logic [3:0] tcls;
        logic       closed;
        cls = byte_kind(b);
        closed = 1'b0;
        if (lex_kind == K_ATOM || lex_kind == K_SPACE) begin
            run = (lex_kind == K_ATOM) ? C_ATOM : C_SPACE;
            if (cls == run) begin
                if (lex_len != 16'hFFFF) lex_len++;
                if (last) begin
                    emit_token(run, lex_len, 1'b0, 1'b1);
                    clear_lexer();
                end
                return;
            end
            emit_token(run, lex_len, 1'b0, 1'b0);
            clear_lexer();
        end else if (lex_kind == K_ESCAPE) begin
            emit_token(C_ESCAPED, 16'd2, 1'b0, last);
            clear_lexer();
            return;
        end else if (lex_kind != K_NONE) begin
            tcls = (lex_kind == K_COMMENT) ? C_COMMENT :
                   (lex_kind == K_QUOTED)  ? C_QUOTED  : C_DOMLIT;
            if (lex_len != 16'hFFFF) lex_len++;
            if (lex_esc) begin
                lex_esc = 1'b0;
            end else if (b == CH_BSLASH) begin
                lex_esc = 1'b1;
            end else if (lex_kind == K_COMMENT) begin
                if (b == CH_LPAREN) begin
                    if (lex_depth != 8'd255) lex_depth++;
                end else if (b == CH_RPAREN) begin
                    if (lex_depth != 8'd0) lex_depth--;
                    else closed = 1'b1;
                end
            end else if (lex_kind == K_QUOTED) begin
                closed = (b == CH_DQUOTE);
            end else begin
                closed = (b == CH_RBRACK);
            end
            if (closed || last) begin
                emit_token(tcls, lex_len, !closed, last);
                clear_lexer();
            end
            return;
        end

        // this byte opens a new token
        case (cls)
            C_ATOM, C_SPACE: begin
                if (last) begin
                    emit_token(cls, 16'd1, 1'b0, 1'b1);
                end else begin
                    lex_kind = (cls == C_ATOM) ? K_ATOM : K_SPACE;
                    lex_len  = 16'd1;
                end
            end
            C_COMMENT, C_QUOTED, C_DOMLIT: begin
                if (last) begin
                    emit_token(cls, 16'd1, 1'b1, 1'b1);
                end else begin
                    lex_kind = (cls == C_COMMENT) ? K_COMMENT :
                               (cls == C_QUOTED)  ? K_QUOTED  : K_DOMLIT;
                    lex_len  = 16'd1;
                end
            end
            C_ESCAPED: begin
                if (last) begin
                    emit_token(C_ESCAPED, 16'd1, 1'b1, 1'b1);
                end else begin
                    lex_kind = K_ESCAPE;
                    lex_len  = 16'd1;
                end
            end
            default: emit_token(cls, 16'd1, 1'b0, last);
        endcase
    endtask

    // sender: the posedge half records transfers, the negedge half presents bytes
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            lex_byte(s_tdata, s_tlast);
            holding = 1'b0;
        end
    end

    always @(negedge aclk) begin
        hdr_byte_t cur;
        if (aresetn && !holding) begin
            if (header_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                cur = header_bytes.pop_front();
                s_tdata  <= cur.b;
                s_tlast  <= cur.last;
                s_tvalid <= 1'b1;
                holding = 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= aresetn && ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[3:0], m_tdata[19:4], m_tuser, m_tlast};
            if (expected_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected token class %0d len %0d unterm %0b final %0b",
                             $realtime, got.token_class, got.token_length,
                             got.unterminated, got.final_token);
            end else begin
                want = expected_tokens.pop_front();
                if (got != want || m_tdata[23:20] != 4'd0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display(
                            "%0t: mismatch class %0d/%0d len %0d/%0d unterm %0b/%0b fin %0b/%0b pad %h",
                            $realtime, want.token_class, got.token_class,
                            want.token_length, got.token_length,
                            want.unterminated, got.unterminated,
                            want.final_token, got.final_token, m_tdata[23:20]);
                end
            end
        end
    end

    // move the built string to the send queue; cut > 0 truncates it there
    task automatic flush_string(input int cut);
        hdr_byte_t it;
        if (cut > 0 && cut < str_q.size())
            str_q = str_q[0:cut-1];
        for (int i = 0; i < str_q.size(); i++) begin
            it.b    = str_q[i];
            it.last = (i == str_q.size() - 1);
            header_bytes.push_back(it);
            queued++;
        end
        str_q.delete();
    endtask

    function automatic logic [7:0] pick_class(input logic [3:0] want);
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (byte_kind(b) != want);
        return b;
    endfunction

    task automatic add_delimited(input logic [7:0] open_b, input logic [7:0] close_b,
                                 input bit nested);
        int depth;
        int steps;
        int r;
        logic [7:0] b;
        depth = 0;
        steps = $urandom_range(0, 6);
        // opener may carry bit 7: only its low seven bits pick the class
        str_q.push_back(open_b | (($urandom_range(0, 3) == 0) ? 8'h80 : 8'h00));
        repeat (steps) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
                str_q.push_back(CH_BSLASH);
                str_q.push_back(8'($urandom_range(1, 255)));
            end else if (r == 1 && nested && depth < 3) begin
                str_q.push_back(CH_LPAREN);
                depth++;
            end else if (r == 2 && nested && depth > 0) begin
                str_q.push_back(CH_RPAREN);
                depth--;
            end else begin
                do
                    b = 8'($urandom_range(1, 255));
                while (b == CH_BSLASH || b == close_b || (nested && b == CH_LPAREN));
                str_q.push_back(b);
            end
        end
        repeat (depth) str_q.push_back(CH_RPAREN);
        str_q.push_back(close_b);
    endtask

    task automatic add_token();
        case ($urandom_range(0, 8))
            0: repeat ($urandom_range(1, 6)) str_q.push_back(pick_class(C_ATOM));
            1: repeat ($urandom_range(1, 3)) str_q.push_back(pick_class(C_SPACE));
            2: add_delimited(CH_LPAREN, CH_RPAREN, 1'b1);
            3: add_delimited(CH_DQUOTE, CH_DQUOTE, 1'b0);
            4: begin
                str_q.push_back(CH_BSLASH);
                str_q.push_back(8'($urandom_range(1, 255)));
            end
            5: add_delimited(8'h5B, CH_RBRACK, 1'b0);
            6: str_q.push_back(pick_class(C_SPECIAL));
            7: str_q.push_back(pick_class(C_CONTROL));
            default: str_q.push_back(pick_class(C_HIGH));
        endcase
    endtask

    // mostly well-formed header strings, some cut short, some pure noise
    task automatic gen_headers(input int n);
        int start;
        int r;
        start = queued;
        while (queued - start < n) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
                repeat ($urandom_range(1, 12)) str_q.push_back(8'($urandom_range(1, 255)));
                flush_string(0);
            end else begin
                repeat ($urandom_range(1, 8)) add_token();
                flush_string((r == 1) ? $urandom_range(1, str_q.size()) : 0);
            end
        end
    endtask

    task automatic drain();
        while (header_bytes.size() != 0 || holding || expected_tokens.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle = 33;
        recv_idle = 61;
        // atom run closed by the high byte
        str_q = '{8'h41, 8'hC2, 8'h80};                 flush_string(0);
        // space run with a bit-7 tab, then a special
        str_q = '{8'h20, 8'h89, 8'h40};                 flush_string(0);
        // control, DEL as atom, backslash pair, special
        str_q = '{8'h01, 8'h7F, 8'h5C, 8'hFF, 8'h3B};   flush_string(0);
        // nested comment, escaped paren, bit-7 paren does not close
        str_q = '{8'h28, 8'h28, 8'h5C, 8'h29, 8'h29, 8'hA9, 8'h29}; flush_string(0);
        str_q = '{8'h22, 8'h78, 8'h5C, 8'h22, 8'hA2, 8'h22, 8'h20}; flush_string(0);
        str_q = '{8'h5B, 8'h61, 8'hDD, 8'h5D};          flush_string(0);
        // comment opened by a bit-7 paren
        str_q = '{8'hA8, 8'h29, 8'h7E};                 flush_string(0);
        str_q = '{8'h61, 8'h20};                        flush_string(0);
        // strings that end inside open tokens, and an escape pair that ends a string
        str_q = '{8'h22};                               flush_string(0);
        str_q = '{8'h5C};                               flush_string(0);
        str_q = '{8'h28, 8'h61};                        flush_string(0);
        str_q = '{8'h5C, 8'h71};                        flush_string(0);
        gen_headers(200);
        drain();

        send_idle = 61;
        recv_idle = 33;
        gen_headers(200);
        drain();

        send_idle = 0;
        recv_idle = 0;
        gen_headers(200);
        drain();

        repeat (20) @(posedge aclk);
        if (expected_tokens.size() != 0)
            $display("%0d expected tokens never arrived", expected_tokens.size());
        if (mismatches == 0 && expected_tokens.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
